// File: sv/slist_pkg.sv
// Shared constants, codes and types for the sequential list engine.
`default_nettype none

package slist_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int KIND_W   = 3;
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;
   localparam int OUT_W    = 9;
   localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_GET    = 3'd3,
      KIND_LOCATE = 3'd4,
      KIND_PRIOR  = 3'd5,
      KIND_NEXT   = 3'd6,
      KIND_CLEAR  = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_PUT,
      ST_MOVE_DOWN,
      ST_SCAN,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] result_value;
      logic [OUT_W-1:0]         found_position;
      logic [OUT_W-1:0]         list_length;
   } res_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

// File: sv/slist_if.sv
// Request and response channel interfaces with valid/ready handshake.
`default_nettype none

interface slist_req_if;
   import slist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface slist_rsp_if;
   import slist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [DATA_W-1:0] result_value;
   logic [OUT_W-1:0]         found_position;
   logic [OUT_W-1:0]         list_length;

   modport source (output valid, ok, result_value, found_position, list_length, input ready);
   modport sink   (input valid, ok, result_value, found_position, list_length, output ready);
endinterface

`default_nettype wire

// File: sv/slist_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module slist_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/slist_seq.sv
// Request sequencer: shifts, reads and scans the list memory one entry a cycle.
`default_nettype none

module slist_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   slist_req_if.sink                   req_chan,
   output      logic                   done_valid,
   input  wire logic                   done_take,
   output      slist_pkg::res_type     done_res,
   output      slist_pkg::mem_req_type mem_req,
   input  wire logic [slist_pkg::DATA_W-1:0] mem_rd_data
);
   import slist_pkg::*;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   ptr_ff, ptr_in;
   logic [LEN_W-1:0]   last_ff, last_in;
   logic               iss_ff, iss_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [LEN_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [DATA_W-1:0]  prev_ff, prev_in;
   logic               ok_ff, ok_in;
   logic [DATA_W-1:0]  rv_ff, rv_in;
   logic [OUT_W-1:0]   fp_ff, fp_in;

   logic               req_take;
   kind_type           req_kind;
   logic [CMP_W-1:0]   pos_x;
   logic [CMP_W-1:0]   len_x;
   logic [CMP_W-1:0]   ins_pos;
   logic               full;

   assign req_take = req_chan.valid && req_chan.ready;
   assign req_kind = kind_type'(req_chan.kind);
   assign pos_x    = CMP_W'(req_chan.position);
   assign len_x    = CMP_W'(len_ff);
   assign full     = (len_ff == LEN_W'(CAPACITY));
   assign ins_pos  = (req_kind == KIND_APPEND) ? (len_x + CMP_W'(1)) : pos_x;

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      iss_in     = iss_ff;
      rd_pend_in = mem_req.rd_en;
      rd_addr_in = ptr_ff;
      prev_in    = prev_ff;
      ok_in      = ok_ff;
      rv_in      = rv_ff;
      fp_in      = fp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in  = req_kind;
               value_in = req_chan.value;
               ok_in    = 1'b0;
               rv_in    = '0;
               fp_in    = '0;
               unique case (req_kind)
                  KIND_INSERT, KIND_APPEND: begin
                     if (full || ins_pos == '0 || ins_pos > len_x + CMP_W'(1)) begin
                        state_in = ST_DONE;
                     end else begin
                        idx_in   = LEN_W'(ins_pos - CMP_W'(1));
                        ptr_in   = len_ff - LEN_W'(1);
                        iss_in   = 1'b1;
                        state_in = (LEN_W'(ins_pos - CMP_W'(1)) == len_ff) ? ST_PUT : ST_SHIFT_UP;
                     end
                  end
                  KIND_DELETE, KIND_GET: begin
                     if (pos_x == '0 || pos_x > len_x) begin
                        state_in = ST_DONE;
                     end else begin
                        idx_in   = LEN_W'(pos_x - CMP_W'(1));
                        ptr_in   = LEN_W'(pos_x - CMP_W'(1));
                        last_in  = (req_kind == KIND_DELETE) ? (len_ff - LEN_W'(1))
                                                             : LEN_W'(pos_x - CMP_W'(1));
                        iss_in   = 1'b1;
                        state_in = ST_MOVE_DOWN;
                     end
                  end
                  KIND_LOCATE, KIND_PRIOR, KIND_NEXT: begin
                     if (len_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        ptr_in   = '0;
                        last_in  = len_ff - LEN_W'(1);
                        iss_in   = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_CLEAR: begin
                     len_in   = '0;
                     ok_in    = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SHIFT_UP: begin
            // walk down from the tail, each entry moves one place up
            if (iss_ff) begin
               if (ptr_ff == idx_ff) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - LEN_W'(1);
               end
            end
            if (!iss_ff && !rd_pend_ff) begin
               state_in = ST_PUT;
            end
         end

         ST_PUT: begin
            len_in   = len_ff + LEN_W'(1);
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end

         ST_MOVE_DOWN: begin
            if (iss_ff) begin
               if (ptr_ff == last_ff) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + LEN_W'(1);
               end
            end
            if (rd_pend_ff && rd_addr_ff == idx_ff) begin
               rv_in = mem_rd_data;
            end
            if (!iss_ff && !rd_pend_ff) begin
               if (kind_ff == KIND_DELETE) begin
                  len_in = len_ff - LEN_W'(1);
               end
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_SCAN: begin
            if (iss_ff) begin
               if (ptr_ff == last_ff) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + LEN_W'(1);
               end
            end
            if (rd_pend_ff) begin
               prev_in = mem_rd_data;
               if (mem_rd_data == value_ff) begin
                  priority case (kind_ff)
                     KIND_LOCATE: begin
                        ok_in    = 1'b1;
                        fp_in    = OUT_W'(rd_addr_ff + LEN_W'(1));
                        state_in = ST_DONE;
                     end
                     KIND_PRIOR: begin
                        if (rd_addr_ff != '0) begin
                           ok_in = 1'b1;
                           rv_in = prev_ff;
                        end
                        state_in = ST_DONE;
                     end
                     default: begin
                        // the read of the following entry is already in flight
                        state_in = (rd_addr_ff < last_ff) ? ST_NEXT : ST_DONE;
                     end
                  endcase
               end else if (!iss_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_NEXT: begin
            ok_in    = 1'b1;
            rv_in    = mem_rd_data;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_chan.ready  = (state_ff == ST_IDLE);
      done_valid      = (state_ff == ST_DONE);
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = ADDR_W'(ptr_ff);
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ADDR_W'(rd_addr_ff + LEN_W'(1));
      mem_req.wr_data = mem_rd_data;

      unique case (state_ff)
         ST_SHIFT_UP: begin
            mem_req.rd_en = iss_ff;
            mem_req.wr_en = rd_pend_ff;
         end
         ST_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_W'(idx_ff);
            mem_req.wr_data = value_ff;
         end
         ST_MOVE_DOWN: begin
            mem_req.rd_en   = iss_ff;
            mem_req.wr_en   = rd_pend_ff && (rd_addr_ff != idx_ff);
            mem_req.wr_addr = ADDR_W'(rd_addr_ff - LEN_W'(1));
         end
         ST_SCAN: begin
            mem_req.rd_en = iss_ff;
         end
         default: begin
         end
      endcase
   end

   assign done_res.ok             = ok_ff;
   assign done_res.result_value   = rv_ff;
   assign done_res.found_position = fp_ff;
   assign done_res.list_length    = OUT_W'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         iss_ff     <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         iss_ff     <= iss_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      idx_ff     <= idx_in;
      ptr_ff     <= ptr_in;
      last_ff    <= last_in;
      rd_addr_ff <= rd_addr_in;
      prev_ff    <= prev_in;
      ok_ff      <= ok_in;
      rv_ff      <= rv_in;
      fp_ff      <= fp_in;
   end

endmodule

`default_nettype wire

// File: sv/sequential_list_engine_core.sv
// Top level of the sequential list engine: sequencer, list memory and response register.
//
//  channel   | dir | handshake      | payload
//  req_chan  | in  | valid / ready  | kind, position, value
//  rsp_chan  | out | valid / ready  | ok, result_value, found_position, list_length
//
// One request at a time. The next request can be taken in the cycle after the response is loaded,
// and a walk over the list memory uses its single read port, one entry per cycle.
// Reset is synchronous and empties the list; entry contents are left as they are.
// A finished response waits in the output register while the next request is taken.
`default_nettype none

module sequential_list_engine_core (
   input wire logic   clock,
   input wire logic   reset,
   slist_req_if.sink   req_chan,
   slist_rsp_if.source rsp_chan
);
   import slist_pkg::*;

   logic                 done_valid;
   logic                 done_take;
   res_type              done_res;
   mem_req_type          mem_req;
   logic [DATA_W-1:0]    mem_rd_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_res_ff, rsp_res_in;

   slist_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .done_valid  (done_valid),
      .done_take   (done_take),
      .done_res    (done_res),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   slist_ram #(
      .DEPTH  (CAPACITY),
      .WIDTH  (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data)
   );

   // load the response register when it is empty or being drained
   assign done_take = done_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = done_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = rsp_res_ff.ok;
   assign rsp_chan.result_value   = rsp_res_ff.result_value;
   assign rsp_chan.found_position = rsp_res_ff.found_position;
   assign rsp_chan.list_length    = rsp_res_ff.list_length;

endmodule

`default_nettype wire
